// ===== hw/rtl/sstd_pkg.sv =====
// Shared widths, reciprocal constants, calendar table and payload types
// for the serial date-time converter. No dependencies.

package sstd_pkg;

	localparam int NSTAGE = 10;

	// payload widths
	localparam int DAY_W  = 23;
	localparam int FRAC_W = 32;
	localparam int YEAR_W = 14;
	localparam int MON_W  = 4;
	localparam int DOM_W  = 5;
	localparam int HOUR_W = 5;
	localparam int MIN_W  = 6;
	localparam int SEC_W  = 6;

	// internal widths
	localparam int Z_W    = 23;
	localparam int SECS_W = 17;
	localparam int REMH_W = 12;
	localparam int DOE_W  = 18;
	localparam int ERA_W  = 6;
	localparam int YOE_W  = 9;
	localparam int DOY_W  = 9;
	localparam int MP_W   = 4;
	localparam int Q4Y_W  = 7;
	localparam int QC_W   = 3;

	// day count from 0000-03-01 to the epoch of each date system
	localparam logic [Z_W-1:0]   BASE_1900 = 23'd693900;
	localparam logic [Z_W-1:0]   BASE_1904 = 23'd695361;
	localparam logic [DAY_W-2:0] LEAP_DAY  = 22'd60;
	localparam logic [YEAR_W-1:0] YEAR_1900 = 14'd1900;
	localparam logic [MON_W-1:0]  MON_JAN   = 4'd1;

	// fraction of a day to rounded seconds
	localparam logic [SECS_W-1:0] DAY_SECS  = 17'd86400;
	localparam int                FRAC_SH   = 32;

	// reciprocals: ceil(2^SH / D), exact over each operand's range
	localparam logic [DOE_W-1:0] ERA_DAYS = 18'd146097;
	localparam logic [DOE_W-1:0] ERA_LAST = 18'd146096;
	localparam int               ERA_SH   = 40;
	localparam logic [22:0]      ERA_RCP  =
		23'(((64'd1 << ERA_SH) + 64'd146097 - 64'd1) / 64'd146097);

	localparam int          C4Y_SH  = 28;
	localparam logic [17:0] C4Y_RCP = 18'(((64'd1 << C4Y_SH) + 64'd1459) / 64'd1460);

	localparam int          CENT_SH  = 33;
	localparam logic [17:0] CENT_RCP = 18'(((64'd1 << CENT_SH) + 64'd36523) / 64'd36524);

	localparam logic [DOY_W-1:0] YEAR_DAYS = 9'd365;
	localparam int               YR_SH     = 26;
	localparam logic [17:0]      YR_RCP    = 18'(((64'd1 << YR_SH) + 64'd364) / 64'd365);

	localparam int         C100_SH  = 16;
	localparam logic [9:0] C100_RCP = 10'(((64'd1 << C100_SH) + 64'd99) / 64'd100);

	localparam int          MON_SH  = 19;
	localparam logic [11:0] MON_RCP = 12'(((64'd1 << MON_SH) + 64'd152) / 64'd153);

	localparam logic [REMH_W-1:0] HOUR_SECS = 12'd3600;
	localparam int                HOUR_SH   = 29;
	localparam logic [17:0]       HOUR_RCP  = 18'(((64'd1 << HOUR_SH) + 64'd3599) / 64'd3600);

	localparam logic [SEC_W-1:0]  MIN_SECS = 6'd60;
	localparam int                MIN_SH   = 18;
	localparam logic [12:0]       MIN_RCP  = 13'(((64'd1 << MIN_SH) + 64'd59) / 64'd60);

	localparam logic [YEAR_W-1:0] ERA_YEARS = 14'd400;

	typedef logic [NSTAGE:1] sstd_stage_vec_t;

	typedef struct packed {
		logic neg;
		logic day0;
	} sstd_flags_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [MON_W-1:0]  month;
		logic [DOM_W-1:0]  day_of_month;
	} sstd_date_t;

	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
	} sstd_tod_t;

	// days from 1 March to the first of the month, March-based month index
	function automatic logic [DOY_W-1:0] days_before(input logic [MP_W-1:0] mp);
		logic [DOY_W-1:0] d;
		case (mp)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd61;
			4'd3:    d = 9'd92;
			4'd4:    d = 9'd122;
			4'd5:    d = 9'd153;
			4'd6:    d = 9'd184;
			4'd7:    d = 9'd214;
			4'd8:    d = 9'd245;
			4'd9:    d = 9'd275;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ===== hw/rtl/sstd_if.sv =====
// Valid/ready channels for serial requests and calendar results.
// Depends on sstd_pkg for the field widths.

interface sstd_req_if import sstd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DAY_W-1:0]  day_number;
	logic [FRAC_W-1:0]        day_fraction;

	modport source(output valid, day_number, day_fraction, input ready);
	modport sink(input valid, day_number, day_fraction, output ready);
endinterface

interface sstd_res_if import sstd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [YEAR_W-1:0] year;
	logic [MON_W-1:0]  month;
	logic [DOM_W-1:0]  day_of_month;
	logic [HOUR_W-1:0] hour;
	logic [MIN_W-1:0]  minute;
	logic [SEC_W-1:0]  second;

	modport source(output valid, year, month, day_of_month, hour, minute, second,
		input ready);
	modport sink(input valid, year, month, day_of_month, hour, minute, second,
		output ready);
endinterface

// ===== hw/rtl/sstd_time_path.sv =====
// Time-of-day path: rounded seconds of the day to hour, minute, second.
// Stages 2 to 5 do the work, then a delay line aligns with the date path.
// Depends on sstd_pkg.

module sstd_time_path import sstd_pkg::*; (
	input  logic              clk,
	input  sstd_stage_vec_t   adv,
	input  logic [SECS_W-1:0] secs_s1,
	output sstd_tod_t         tod
);

	logic [SECS_W-1:0]  secs_s2;
	logic [HOUR_W-1:0]  hour_s2, hour_s3, hour_s4;
	logic [REMH_W-1:0]  remh_s3, remh_s4;
	logic [MIN_W-1:0]   minute_s4;
	sstd_tod_t          tod_s [5:NSTAGE];

	logic [34:0]        hprod;
	logic [SECS_W-1:0]  hsecs;
	logic [24:0]        mprod;
	logic [REMH_W-1:0]  msecs;

	assign hprod = 35'(secs_s1) * 35'(HOUR_RCP);
	assign hsecs = 17'(hour_s2) * 17'(HOUR_SECS);
	assign mprod = 25'(remh_s3) * 25'(MIN_RCP);
	assign msecs = 12'(minute_s4) * 12'(MIN_SECS);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			secs_s2 <= secs_s1;
			hour_s2 <= hprod[HOUR_SH +: HOUR_W];
		end
		if (adv[3]) begin
			hour_s3 <= hour_s2;
			remh_s3 <= REMH_W'(secs_s2 - hsecs);
		end
		if (adv[4]) begin
			hour_s4   <= hour_s3;
			remh_s4   <= remh_s3;
			minute_s4 <= mprod[MIN_SH +: MIN_W];
		end
		if (adv[5]) begin
			tod_s[5].hour   <= hour_s4;
			tod_s[5].minute <= minute_s4;
			tod_s[5].second <= SEC_W'(remh_s4 - msecs);
		end
		for (int i = 6; i <= NSTAGE; i++) begin
			if (adv[i])
				tod_s[i] <= tod_s[i-1];
		end
	end

	assign tod = tod_s[NSTAGE];

endmodule

// ===== hw/rtl/sstd_date_path.sv =====
// Date path: day count since 0000-03-01 to Gregorian year, month, day.
// Nine register stages (2 to 10), with the reciprocal multiplies spread across them.
// Depends on sstd_pkg.

module sstd_date_path import sstd_pkg::*; (
	input  logic            clk,
	input  sstd_stage_vec_t adv,
	input  logic [Z_W-1:0]  z_s1,
	output sstd_date_t      date
);

	logic [Z_W-1:0]    z_s2;
	logic [ERA_W-1:0]  era_s2, era_s3, era_s4, era_s5, era_s6, era_s7, era_s8, era_s9;
	logic [DOE_W-1:0]  doe_s3, doe_s4, doe_s5, doe_s6, doe_s7;
	logic [Q4Y_W-1:0]  q4y_s4;
	logic [QC_W-1:0]   qc_s4;
	logic              qe_s4;
	logic [DOE_W-1:0]  t_s5;
	logic [YOE_W-1:0]  yoe_s6, yoe_s7, yoe_s8, yoe_s9;
	logic [QC_W-1:0]   c100_s7;
	logic [DOE_W-1:0]  y365_s7;
	logic [DOY_W-1:0]  doy_s8, doy_s9;
	logic [MP_W-1:0]   mp_s9;
	sstd_date_t        date_s10;

	logic [45:0]       eprod;
	logic [Z_W-1:0]    edays;
	logic [35:0]       p4y, pcent, pyr;
	logic [18:0]       pc100;
	logic [10:0]       mnum;
	logic [22:0]       pmon;
	logic [MON_W-1:0]  mon_d;
	logic [YEAR_W-1:0] year_d;

	assign eprod = 46'(z_s1) * 46'(ERA_RCP);
	assign edays = 23'(era_s2) * 23'(ERA_DAYS);
	assign p4y   = 36'(doe_s3) * 36'(C4Y_RCP);
	assign pcent = 36'(doe_s3) * 36'(CENT_RCP);
	assign pyr   = 36'(t_s5) * 36'(YR_RCP);
	assign pc100 = 19'(yoe_s6) * 19'(C100_RCP);
	assign mnum  = {doy_s8, 2'b00} + 11'(doy_s8) + 11'd2;
	assign pmon  = 23'(mnum) * 23'(MON_RCP);

	// March-based index back to calendar month; Jan/Feb belong to the next year
	always_comb begin
		if (mp_s9 < 4'd10)
			mon_d = mp_s9 + 4'd3;
		else
			mon_d = mp_s9 - 4'd9;
		year_d = 14'(yoe_s9) + 14'(era_s9) * ERA_YEARS + 14'(mon_d <= 4'd2);
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			z_s2   <= z_s1;
			era_s2 <= eprod[ERA_SH +: ERA_W];
		end
		if (adv[3]) begin
			era_s3 <= era_s2;
			doe_s3 <= DOE_W'(z_s2 - edays);
		end
		if (adv[4]) begin
			era_s4 <= era_s3;
			doe_s4 <= doe_s3;
			q4y_s4 <= p4y[C4Y_SH +: Q4Y_W];
			qc_s4  <= pcent[CENT_SH +: QC_W];
			qe_s4  <= (doe_s3 == ERA_LAST);
		end
		if (adv[5]) begin
			era_s5 <= era_s4;
			doe_s5 <= doe_s4;
			t_s5   <= doe_s4 - DOE_W'(q4y_s4) + DOE_W'(qc_s4) - DOE_W'(qe_s4);
		end
		if (adv[6]) begin
			era_s6 <= era_s5;
			doe_s6 <= doe_s5;
			yoe_s6 <= pyr[YR_SH +: YOE_W];
		end
		if (adv[7]) begin
			era_s7  <= era_s6;
			doe_s7  <= doe_s6;
			yoe_s7  <= yoe_s6;
			c100_s7 <= pc100[C100_SH +: QC_W];
			y365_s7 <= 18'(yoe_s6) * 18'(YEAR_DAYS);
		end
		if (adv[8]) begin
			era_s8 <= era_s7;
			yoe_s8 <= yoe_s7;
			doy_s8 <= DOY_W'(doe_s7 - (y365_s7 + DOE_W'(yoe_s7 >> 2) - DOE_W'(c100_s7)));
		end
		if (adv[9]) begin
			era_s9 <= era_s8;
			yoe_s9 <= yoe_s8;
			doy_s9 <= doy_s8;
			mp_s9  <= pmon[MON_SH +: MP_W];
		end
		if (adv[10]) begin
			date_s10.year         <= year_d;
			date_s10.month        <= mon_d;
			date_s10.day_of_month <= DOM_W'(doy_s9 - days_before(mp_s9) + 9'd1);
		end
	end

	assign date = date_s10;

endmodule

// ===== hw/rtl/spreadsheet_serial_to_datetime_core.sv =====
// Spreadsheet serial date-time to Gregorian date and time of day. One
// request is taken every cycle while req.ready is high; each result passes
// through the entry register and the nine register stages of the date
// path, whose chain of reciprocal multiplies (era, four-year and century
// counts, year of era, month) is spread across those stages. Stalls on the
// result side back up stage by stage, and empty stages keep filling.
// The 1900/1904 date system bit is sampled as each request enters.

module spreadsheet_serial_to_datetime_core import sstd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_wdata,
	sstd_req_if.sink   req,
	sstd_res_if.source res
);

	logic              sys1904_q;
	logic [NSTAGE:1]   vld_q;
	sstd_stage_vec_t   adv;

	logic [Z_W-1:0]    z_s1;
	logic [SECS_W-1:0] secs_s1;
	sstd_flags_t       flg_s [1:NSTAGE];

	logic [DAY_W-2:0]  mag;
	logic [Z_W-1:0]    z_d;
	logic [48:0]       sprod;
	sstd_flags_t       flg_d;
	sstd_date_t        date;
	sstd_tod_t         tod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sys1904_q <= 1'b0;
		else if (cfg_we)
			sys1904_q <= cfg_wdata;
	end

	// a stage moves when it is empty or the one after it moves
	always_comb begin
		adv[NSTAGE] = !vld_q[NSTAGE] || res.ready;
		for (int i = NSTAGE - 1; i >= 1; i--)
			adv[i] = !vld_q[i] || adv[i+1];
	end

	assign req.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1])
				vld_q[1] <= req.valid;
			for (int i = 2; i <= NSTAGE; i++) begin
				if (adv[i])
					vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// 1900 system skips the phantom 29 February from day 60 on
	always_comb begin
		mag = req.day_number[DAY_W-2:0];
		if (sys1904_q)
			z_d = BASE_1904 + Z_W'(mag);
		else
			z_d = BASE_1900 + Z_W'(mag) - Z_W'(mag >= LEAP_DAY);
		sprod      = 49'(req.day_fraction) * 49'(DAY_SECS) + (49'd1 << (FRAC_SH - 1));
		flg_d.neg  = req.day_number[DAY_W-1];
		flg_d.day0 = !sys1904_q && (mag == '0);
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			z_s1     <= z_d;
			secs_s1  <= sprod[FRAC_SH +: SECS_W];
			flg_s[1] <= flg_d;
		end
		for (int i = 2; i <= NSTAGE; i++) begin
			if (adv[i])
				flg_s[i] <= flg_s[i-1];
		end
	end

	sstd_date_path u_date (
		.clk  (clk),
		.adv  (adv),
		.z_s1 (z_s1),
		.date (date)
	);

	sstd_time_path u_time (
		.clk     (clk),
		.adv     (adv),
		.secs_s1 (secs_s1),
		.tod     (tod)
	);

	always_comb begin
		res.valid        = vld_q[NSTAGE];
		res.year         = date.year;
		res.month        = date.month;
		res.day_of_month = date.day_of_month;
		res.hour         = tod.hour;
		res.minute       = tod.minute;
		res.second       = tod.second;
		if (flg_s[NSTAGE].neg) begin
			res.year         = '0;
			res.month        = '0;
			res.day_of_month = '0;
			res.hour         = '0;
			res.minute       = '0;
			res.second       = '0;
		end else if (flg_s[NSTAGE].day0) begin
			res.year         = YEAR_1900;
			res.month        = MON_JAN;
			res.day_of_month = '0;
		end
	end

endmodule

// ===== hw/rtl/sstd_checker.sv =====
// Port-level checks for the converter core, attached by the bind below.
// Depends on sstd_pkg and the top level's ports.

module sstd_checker import sstd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [YEAR_W-1:0] res_year,
	input logic [MON_W-1:0]  res_month,
	input logic [DOM_W-1:0]  res_day_of_month,
	input logic [HOUR_W-1:0] res_hour,
	input logic [MIN_W-1:0]  res_minute,
	input logic [SEC_W-1:0]  res_second
);

	localparam int CNT_W = $clog2(NSTAGE + 1) + 1;

	logic              acc, dlv;
	logic [NSTAGE-1:0] acc_sh_q;
	logic [CNT_W-1:0]  rdy_run_q;
	logic [CNT_W-1:0]  inflight_q;

	assign acc = req_valid && req_ready;
	assign dlv = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_sh_q   <= '0;
			rdy_run_q  <= '0;
			inflight_q <= '0;
		end else begin
			acc_sh_q   <= {acc_sh_q[NSTAGE-2:0], acc};
			if (!res_ready)
				rdy_run_q <= '0;
			else if (rdy_run_q < CNT_W'(NSTAGE))
				rdy_run_q <= rdy_run_q + 1'b1;
			inflight_q <= inflight_q + CNT_W'(acc) - CNT_W'(dlv);
		end
	end

	// no request in flight means nothing to deliver
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> inflight_q != '0)
		else $error("result without an outstanding request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(NSTAGE))
		else $error("more requests in flight than pipeline stages");

	// with the result side always ready, a request comes out when it has passed every stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc_sh_q[NSTAGE-1] && (rdy_run_q >= CNT_W'(NSTAGE - 1)) |-> res_valid)
		else $error("result late on an unstalled pipeline");

	a_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_month == '0) |->
			(res_year == '0) && (res_day_of_month == '0) && (res_hour == '0) &&
			(res_minute == '0) && (res_second == '0))
		else $error("month zero without all-zero fields");

	a_hour_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_hour == 5'd24) |-> (res_minute == '0) && (res_second == '0))
		else $error("hour 24 with non-zero minute or second");

endmodule

bind spreadsheet_serial_to_datetime_core sstd_checker u_sstd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_year         (res.year),
	.res_month        (res.month),
	.res_day_of_month (res.day_of_month),
	.res_hour         (res.hour),
	.res_minute       (res.minute),
	.res_second       (res.second)
);
